@@ hw/rtl/wsu_pkg.sv @@
// Shared types and codes of the watchpoint slot unit.
// Request and response payloads, log and slot entry layouts, status and action codes.
// No dependencies.
`default_nettype none

package wsu_pkg;

  // Request actions
  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_TRAP  = 3'd2;
  localparam logic [2:0] ACT_POP   = 3'd3;
  localparam logic [2:0] ACT_QUERY = 3'd4;

  // Response status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd5;
  localparam logic [2:0] ST_NOT_OURS  = 3'd6;
  localparam logic [2:0] ST_LOG_EMPTY = 3'd7;

  // LEN field codes of the debug control word
  localparam logic [1:0] LEN_CODE_1 = 2'b00;
  localparam logic [1:0] LEN_CODE_2 = 2'b01;
  localparam logic [1:0] LEN_CODE_4 = 2'b11;
  localparam logic [1:0] LEN_CODE_8 = 2'b10;

  // Reset value of a slot's R/W bits: write watch
  localparam logic [1:0] KIND_WRITE = 2'b01;

  // Configuration register indexes
  localparam logic REG_WATCH_ENABLE = 1'b0;

  typedef struct packed {
    logic [2:0]        action;
    logic [63:0]       watch_addr;
    logic [3:0]        watch_len;
    logic [1:0]        watch_kind;
    logic signed [3:0] slot_select;
    logic              is_single_step;
    logic [3:0]        debug_status;
    logic [63:0]       fault_pc;
    logic [31:0]       thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_out;
    logic [31:0] control_word;
    logic [63:0] addr_out;
    logic [3:0]  len_out;
    logic [1:0]  kind_out;
    logic        armed_out;
    logic [63:0] hit_count;
    logic [63:0] seq_out;
    logic [63:0] pc_out;
    logic [31:0] thread_out;
  } rsp_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [63:0] pc;
    logic [63:0] addr;
    logic [31:0] thread;
    logic [1:0]  slot;
  } log_entry_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] hits;
  } slot_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/watchpoint_slot_unit.sv @@
// Watchpoint slot unit: slot table, hit counters and hit log with an APB register port.
// Depends on wsu_pkg for payload types, entry layouts and codes.
`default_nettype none

// Each request has an accept cycle and an execute cycle: the accept cycle issues the reads
// of the slot memory (address and hit count) and of the hit log memory, both with registered reads,
// and the execute cycle computes the response, writes back and loads the response register.
// The execute cycle waits while the response register is full and stalled, and no new request
// is accepted until the execute cycle is done. No clearing pass follows reset: the slot memory
// uses a valid bit per slot and the log is tracked by head, tail and fill count.
// Register watch_enable lies at byte address 0; set requests fail while it is zero.
module watchpoint_slot_unit
  import wsu_pkg::*;
#(
  parameter int SLOT_COUNT = 4,
  parameter int LOG_DEPTH  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_stall,
  input  wire req_t        req,
  output      logic        rsp_valid,
  input  wire logic        rsp_stall,
  output      rsp_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LW     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic watch_enable;

  // Request and slot state
  req_t                  req_q;
  logic [SLOT_COUNT-1:0] armed, armed_next;
  logic [1:0]            kind       [SLOT_COUNT];
  logic [1:0]            kind_next  [SLOT_COUNT];
  logic [3:0]            length     [SLOT_COUNT];
  logic [3:0]            length_next[SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;

  // Memories
  slot_entry_t slot_mem [SLOT_COUNT];
  log_entry_t  log_mem  [LOG_DEPTH];
  slot_entry_t slot_rd;
  logic        slot_rd_valid;
  log_entry_t  log_rd;

  logic [LW-1:0]     head, head_next, tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [63:0]       next_seq, next_seq_next;

  logic              req_take, exec_go, rsp_emit;
  logic [SIDX_W-1:0] slot_raddr, slot_waddr;
  logic              slot_we, log_we;
  slot_entry_t       slot_wdata, slot_cur;
  log_entry_t        log_wdata;
  rsp_t              rsp_next;
  rsp_t              rsp_load;
  logic [31:0]       ctl_next;

  // Lowest status bit that names an existing slot, single-step traps only
  function automatic logic [SIDX_W:0] trap_slot(input logic single, input logic [3:0] dstat);
    logic [SIDX_W:0] r;
    r = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (single && dstat[i]) begin
        r = {1'b1, SIDX_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] len_code(input logic [3:0] len);
    case (len)
      4'd1:    return LEN_CODE_1;
      4'd2:    return LEN_CODE_2;
      4'd4:    return LEN_CODE_4;
      default: return LEN_CODE_8;
    endcase
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WATCH_ENABLE) ? {31'b0, watch_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WATCH_ENABLE) begin
      watch_enable <= pwdata[0];
    end
  end

  // Handshake and sequencing
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign exec_go   = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (req_take) begin
      state <= ST_EXEC;
    end else if (exec_go) begin
      state <= ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
  end

  // Slot read address: trap slot or selected slot
  always_comb begin
    logic [SIDX_W:0] ts;
    ts = trap_slot(req.is_single_step, req.debug_status);
    if (req.action == ACT_TRAP) begin
      slot_raddr = ts[SIDX_W-1:0];
    end else begin
      slot_raddr = req.slot_select[SIDX_W-1:0];
    end
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (exec_go && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (req_take) begin
      slot_rd       <= slot_mem[slot_raddr];
      slot_rd_valid <= slot_valid[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && log_we) begin
      log_mem[tail] <= log_wdata;
    end
    if (req_take) begin
      log_rd <= log_mem[head];
    end
  end

  // A slot never written reads as address 0, count 0
  assign slot_cur = slot_rd_valid ? slot_rd : '0;

  // Execute: response and next state
  always_comb begin
    logic [SIDX_W:0]   ts;
    logic [SIDX_W:0]   free;
    logic              len_ok, addr_bad, sel_neg, sel_big;
    logic [SIDX_W-1:0] sel_idx;
    logic [63:0]       hits_new;
    ts       = trap_slot(req_q.is_single_step, req_q.debug_status);
    free     = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!armed[i]) begin
        free = {1'b1, SIDX_W'(i)};
      end
    end
    len_ok   = (req_q.watch_len == 4'd1) || (req_q.watch_len == 4'd2) ||
               (req_q.watch_len == 4'd4) || (req_q.watch_len == 4'd8);
    addr_bad = (req_q.watch_addr == 64'd0) ||
               ((req_q.watch_addr[3:0] & (req_q.watch_len - 4'd1)) != 4'd0);
    sel_neg  = req_q.slot_select[3];
    sel_big  = !req_q.slot_select[3] &&
               ({1'b0, req_q.slot_select[2:0]} >= 4'(SLOT_COUNT));
    sel_idx  = req_q.slot_select[SIDX_W-1:0];
    hits_new = slot_cur.hits + 64'd1;

    armed_next    = armed;
    kind_next     = kind;
    length_next   = length;
    slot_we       = 1'b0;
    slot_waddr    = ts[SIDX_W-1:0];
    slot_wdata    = '0;
    log_we        = 1'b0;
    log_wdata     = '0;
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    next_seq_next = next_seq;
    rsp_next      = '0;
    rsp_emit      = 1'b1;

    case (req_q.action)
      ACT_SET: begin
        if (!watch_enable) begin
          rsp_next.status = ST_DISABLED;
        end else if (!len_ok) begin
          rsp_next.status = ST_BAD_LEN;
        end else if (addr_bad) begin
          rsp_next.status = ST_BAD_ADDR;
        end else if (!free[SIDX_W]) begin
          rsp_next.status = ST_NO_SLOT;
        end else begin
          slot_we                          = 1'b1;
          slot_waddr                       = free[SIDX_W-1:0];
          slot_wdata.addr                  = req_q.watch_addr;
          slot_wdata.hits                  = 64'd0;
          armed_next[free[SIDX_W-1:0]]     = 1'b1;
          kind_next[free[SIDX_W-1:0]]      = req_q.watch_kind;
          length_next[free[SIDX_W-1:0]]    = req_q.watch_len;
          rsp_next.slot_out                = 2'(free[SIDX_W-1:0]);
        end
      end
      ACT_CLEAR: begin
        if (sel_big) begin
          rsp_next.status = ST_BAD_SLOT;
        end else if (sel_neg) begin
          armed_next = '0;
        end else begin
          armed_next[sel_idx] = 1'b0;
          rsp_next.slot_out   = req_q.slot_select[1:0];
        end
      end
      ACT_TRAP: begin
        if (!ts[SIDX_W]) begin
          rsp_next.status = ST_NOT_OURS;
        end else begin
          slot_we            = 1'b1;
          slot_wdata.addr    = slot_cur.addr;
          slot_wdata.hits    = hits_new;
          rsp_next.slot_out  = 2'(ts[SIDX_W-1:0]);
          rsp_next.addr_out  = slot_cur.addr;
          rsp_next.hit_count = hits_new;
          if (fill < FILL_W'(LOG_DEPTH)) begin
            log_we           = 1'b1;
            log_wdata.seq    = next_seq;
            log_wdata.pc     = req_q.fault_pc;
            log_wdata.addr   = slot_cur.addr;
            log_wdata.thread = req_q.thread_id;
            log_wdata.slot   = 2'(ts[SIDX_W-1:0]);
            rsp_next.seq_out = next_seq;
            next_seq_next    = next_seq + 64'd1;
            tail_next        = (tail == LW'(LOG_DEPTH - 1)) ? '0 : tail + LW'(1);
            fill_next        = fill + FILL_W'(1);
          end
        end
      end
      ACT_POP: begin
        if (fill == '0) begin
          rsp_next.status = ST_LOG_EMPTY;
        end else begin
          rsp_next.slot_out   = log_rd.slot;
          rsp_next.addr_out   = log_rd.addr;
          rsp_next.seq_out    = log_rd.seq;
          rsp_next.pc_out     = log_rd.pc;
          rsp_next.thread_out = log_rd.thread;
          head_next           = (head == LW'(LOG_DEPTH - 1)) ? '0 : head + LW'(1);
          fill_next           = fill - FILL_W'(1);
        end
      end
      ACT_QUERY: begin
        if (sel_neg || sel_big) begin
          rsp_next.status = ST_BAD_SLOT;
        end else begin
          rsp_next.slot_out  = req_q.slot_select[1:0];
          rsp_next.addr_out  = slot_cur.addr;
          rsp_next.len_out   = length[sel_idx];
          rsp_next.kind_out  = kind[sel_idx];
          rsp_next.armed_out = armed[sel_idx];
          rsp_next.hit_count = slot_cur.hits;
        end
      end
      default: begin
        rsp_emit = 1'b0;
      end
    endcase
  end

  // Debug control word from the updated slot table
  always_comb begin
    ctl_next = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (armed_next[i]) begin
        ctl_next[2*i]          = 1'b1;
        ctl_next[16+4*i +: 2]  = kind_next[i];
        ctl_next[18+4*i +: 2]  = len_code(length_next[i]);
      end
    end
  end

  // Control word rides on set and clear responses only
  always_comb begin
    rsp_load = rsp_next;
    if (req_q.action == ACT_SET || req_q.action == ACT_CLEAR) begin
      rsp_load.control_word = ctl_next;
    end
  end

  // Slot table flops
  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= '0;
      slot_valid <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        kind[i]   <= KIND_WRITE;
        length[i] <= 4'd0;
      end
    end else if (exec_go) begin
      armed  <= armed_next;
      kind   <= kind_next;
      length <= length_next;
      if (slot_we) begin
        slot_valid[slot_waddr] <= 1'b1;
      end
    end
  end

  // Log pointers and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      next_seq <= '0;
    end else if (exec_go) begin
      head     <= head_next;
      tail     <= tail_next;
      fill     <= fill_next;
      next_seq <= next_seq_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go && rsp_emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && rsp_emit) begin
      rsp <= rsp_load;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(LOG_DEPTH))
    else $error("log fill count beyond log depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == FILL_W'(LOG_DEPTH)) |-> head == tail)
    else $error("log pointers disagree with fill count");

  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    (exec_go && req_q.action == ACT_POP && fill != '0) |=> fill == $past(fill) - FILL_W'(1))
    else $error("pop did not drop fill count by one");

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == ST_EXEC && !req_stall == 1'b0)
    else $error("accepted request did not enter execute");
`endif

endmodule

`default_nettype wire
